[design/json_string_unescape_decoder_defines.svh]
// Assertion macros shared by the decoder RTL.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef JSON_STRING_UNESCAPE_DECODER_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JSUD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JSUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/jsud_pkg.sv]
`default_nettype none

package jsud_pkg;

    // Request modes on the input stream.
    localparam logic [1:0] MODE_DATA   = 2'd0;
    localparam logic [1:0] MODE_BUFEND = 2'd1;
    localparam logic [1:0] MODE_NEWDOC = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Error codes reported in the results.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SYNTAX = 2'd1;
    localparam logic [1:0] ERR_UTF8   = 2'd2;
    localparam logic [1:0] ERR_POOL   = 2'd3;

    // Pool capacity after reset.
    localparam logic [15:0] POOL_CAP_RESET = 16'd1024;

    // Decoder phase; the error phases latch until a new document starts.
    typedef enum logic [3:0] {
        PH_PLAIN      = 4'd0,
        PH_ESC        = 4'd1,
        PH_HEXHI      = 4'd2,
        PH_WANTBS     = 4'd3,
        PH_WANTU      = 4'd4,
        PH_HEXLO      = 4'd5,
        PH_CONT       = 4'd6,
        PH_IDLE       = 4'd7,
        PH_ERR_SYNTAX = 4'd9,
        PH_ERR_UTF8   = 4'd10,
        PH_ERR_POOL   = 4'd11
    } phase_t;

    // Decoder state carried from one request to the next.
    typedef struct packed {
        phase_t      phase;
        logic [20:0] code_accum;
        logic [9:0]  high_half;
        logic [2:0]  digits_left;
        logic [1:0]  seq_length;
        logic [15:0] pool_fill;
        logic [15:0] string_start;
    } dec_state_t;

    localparam dec_state_t STATE_INIT = '{
        phase:        PH_PLAIN,
        code_accum:   21'd0,
        high_half:    10'd0,
        digits_left:  3'd0,
        seq_length:   2'd0,
        pool_fill:    16'd0,
        string_start: 16'd0
    };

    // All results caused by one request: either up to four decoded bytes,
    // or a single status result (done or error).
    typedef struct packed {
        logic [2:0]       count;
        logic             is_byte;
        logic [3:0][7:0]  bytes;
        logic             done;
        logic [15:0]      length;
        logic [1:0]       err;
    } dec_result_t;

endpackage

`default_nettype wire

[design/json_string_unescape_decoder.sv]
// The first result of a request is presented in the cycle after the request is taken.
// Throughput: one request per cycle while the result register is free; a request that decodes to
// n bytes (up to four) fills the one result register, which is unloaded byte by byte.
// Reset (rst_n low, asynchronous) returns the decoder to the plain phase with an empty pool,
// clears any latched error and empties the output; pool capacity returns to 1024 bytes.
`default_nettype none
`include "json_string_unescape_decoder_defines.svh"

module json_string_unescape_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Pool capacity register write.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [0] out_valid, [8:1] decoded_byte, [9] string_done,
                                        // [25:10] decoded_length, [27:26] error_code,
                                        // [31:28] zero
    output logic             m_tlast
);

    jsud_pkg::dec_state_t   state_reg;
    jsud_pkg::dec_state_t   state_next;
    jsud_pkg::dec_result_t  res_next;
    jsud_pkg::dec_result_t  chunk_reg;
    logic                   chunk_valid_reg;
    logic [1:0]             idx_reg;
    logic [15:0]            cap_reg;
    logic                   in_take;
    logic                   out_take;
    logic                   at_last;
    logic                   out_is_byte;
    logic [7:0]             out_byte;

    // Decode step.
    jsud_step u_step (
        .mode          (s_tuser),
        .in_byte       (s_tdata),
        .pool_capacity (cap_reg),
        .st            (state_reg),
        .st_next       (state_next),
        .res           (res_next)
    );

    // Handshakes: a new request is taken whenever the result register is
    // empty or its last result leaves in this cycle.
    assign cfg_ready = 1'b1;
    assign out_take  = chunk_valid_reg && m_tready;
    assign at_last   = ({1'b0, idx_reg} == (chunk_reg.count - 3'd1));
    assign s_tready  = !chunk_valid_reg || (out_take && at_last);
    assign in_take   = s_tvalid && s_tready;

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= jsud_pkg::STATE_INIT;
            cap_reg         <= jsud_pkg::POOL_CAP_RESET;
            chunk_valid_reg <= 1'b0;
            idx_reg         <= 2'd0;
        end
        else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (in_take) begin
                state_reg <= state_next;
            end
            if (in_take && res_next.count != 3'd0) begin
                chunk_valid_reg <= 1'b1;
                idx_reg         <= 2'd0;
            end
            else if (out_take) begin
                if (at_last) begin
                    chunk_valid_reg <= 1'b0;
                end
                else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_take && res_next.count != 3'd0) begin
            chunk_reg <= res_next;
        end
    end

    // Present the current result of the chunk.
    assign out_is_byte = chunk_reg.is_byte;
    assign out_byte    = out_is_byte ? chunk_reg.bytes[idx_reg] : 8'd0;
    assign m_tvalid    = chunk_valid_reg;
    assign m_tlast     = at_last;
    assign m_tdata     = {4'd0,
                          out_is_byte ? jsud_pkg::ERR_NONE : chunk_reg.err,
                          out_is_byte ? 16'd0 : chunk_reg.length,
                          out_is_byte ? 1'b0 : chunk_reg.done,
                          out_byte,
                          out_is_byte};

    // Checks on the result register and pool accounting.
    `JSUD_ASSERT_NOW(a_idx_in_chunk, chunk_valid_reg,
        (chunk_reg.count != 3'd0) && ({1'b0, idx_reg} < chunk_reg.count),
        "result index outside the loaded chunk")
    `JSUD_ASSERT_NOW(a_status_single, chunk_valid_reg && !chunk_reg.is_byte,
        chunk_reg.count == 3'd1, "status result is not alone in its chunk")
    `JSUD_ASSERT_NEXT(a_fill_monotonic, in_take && s_tuser != jsud_pkg::MODE_NEWDOC,
        state_reg.pool_fill >= $past(state_reg.pool_fill),
        "pool fill fell without a new document")

endmodule

`default_nettype wire

[design/jsud_step.sv]
`default_nettype none

// One decode step: current state and one request in, next state and the
// whole chunk of results out, all combinational.
module jsud_step (
    input  wire logic [1:0]         mode,
    input  wire logic [7:0]         in_byte,
    input  wire logic [15:0]        pool_capacity,
    input  wire jsud_pkg::dec_state_t st,
    output jsud_pkg::dec_state_t    st_next,
    output jsud_pkg::dec_result_t   res
);

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_EMIT,
        ACT_ERROR,
        ACT_DONE,
        ACT_CLEAR
    } act_t;

    act_t                  act;
    logic [1:0]            act_code;
    logic [20:0]           act_cp;
    jsud_pkg::dec_state_t  st_work;
    logic [3:0][7:0]       enc_bytes;
    logic [2:0]            enc_n;
    logic [16:0]           fill_sum;
    logic                  pool_ok;

    // Hex digit decode: bit 4 flags a valid digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic jsud_pkg::phase_t phase_of_err(input logic [1:0] code);
        jsud_pkg::phase_t p;
        case (code)
            jsud_pkg::ERR_UTF8: p = jsud_pkg::PH_ERR_UTF8;
            jsud_pkg::ERR_POOL: p = jsud_pkg::PH_ERR_POOL;
            default:            p = jsud_pkg::PH_ERR_SYNTAX;
        endcase
        return p;
    endfunction

    // Work out what this request does and the decode state it leaves.
    always_comb
    begin
        logic [4:0]        hx;
        logic [15:0]       acc16;
        logic [20:0]       acc21;
        logic [2:0]        dl;
        jsud_pkg::phase_t  ph;

        act      = ACT_NONE;
        act_code = jsud_pkg::ERR_NONE;
        act_cp   = 21'd0;
        st_work  = st;
        hx       = hex_decode(in_byte);
        acc16    = {st.code_accum[11:0], hx[3:0]};
        acc21    = {st.code_accum[14:0], in_byte[5:0]};
        dl       = st.digits_left - 3'd1;
        ph       = (st.phase == jsud_pkg::PH_IDLE) ? jsud_pkg::PH_PLAIN : st.phase;

        if (mode == jsud_pkg::MODE_NEWDOC) begin
            act = ACT_CLEAR;
        end
        else if (mode == jsud_pkg::MODE_UNUSED) begin
            act = ACT_NONE;
        end
        else if (st.phase inside {jsud_pkg::PH_ERR_SYNTAX, jsud_pkg::PH_ERR_UTF8,
                                  jsud_pkg::PH_ERR_POOL}) begin
            // Latched error: repeat the code until a new document.
            act      = ACT_ERROR;
            act_code = st.phase[1:0];
        end
        else if (mode == jsud_pkg::MODE_BUFEND) begin
            if (st.phase == jsud_pkg::PH_IDLE) begin
                act = ACT_NONE;
            end
            else if (st.phase inside {jsud_pkg::PH_CONT, jsud_pkg::PH_WANTBS,
                                      jsud_pkg::PH_WANTU}) begin
                act      = ACT_ERROR;
                act_code = jsud_pkg::ERR_UTF8;
            end
            else begin
                act      = ACT_ERROR;
                act_code = jsud_pkg::ERR_SYNTAX;
            end
        end
        else begin
            st_work.phase = ph;
            case (ph)
                jsud_pkg::PH_PLAIN:
                begin
                    if (in_byte == 8'h22) begin
                        act = ACT_DONE;
                    end
                    else if (in_byte < 8'h20) begin
                        act      = ACT_ERROR;
                        act_code = jsud_pkg::ERR_SYNTAX;
                    end
                    else if (in_byte == 8'h5C) begin
                        st_work.phase = jsud_pkg::PH_ESC;
                    end
                    else if (!in_byte[7]) begin
                        act    = ACT_EMIT;
                        act_cp = {13'd0, in_byte};
                    end
                    else if (in_byte[7:5] == 3'b110) begin
                        if (in_byte[4:0] < 5'd2) begin
                            act      = ACT_ERROR;
                            act_code = jsud_pkg::ERR_UTF8;
                        end
                        else begin
                            st_work.seq_length  = 2'd1;
                            st_work.digits_left = 3'd1;
                            st_work.code_accum  = {16'd0, in_byte[4:0]};
                            st_work.phase       = jsud_pkg::PH_CONT;
                        end
                    end
                    else if (in_byte[7:4] == 4'b1110) begin
                        st_work.seq_length  = 2'd2;
                        st_work.digits_left = 3'd2;
                        st_work.code_accum  = {17'd0, in_byte[3:0]};
                        st_work.phase       = jsud_pkg::PH_CONT;
                    end
                    else if (in_byte[7:3] == 5'b11110) begin
                        if (in_byte[2:0] > 3'd4) begin
                            act      = ACT_ERROR;
                            act_code = jsud_pkg::ERR_UTF8;
                        end
                        else begin
                            st_work.seq_length  = 2'd3;
                            st_work.digits_left = 3'd3;
                            st_work.code_accum  = {18'd0, in_byte[2:0]};
                            st_work.phase       = jsud_pkg::PH_CONT;
                        end
                    end
                    else begin
                        act      = ACT_ERROR;
                        act_code = jsud_pkg::ERR_UTF8;
                    end
                end
                jsud_pkg::PH_CONT:
                begin
                    if (in_byte[7:6] != 2'b10) begin
                        act      = ACT_ERROR;
                        act_code = jsud_pkg::ERR_UTF8;
                    end
                    else begin
                        st_work.code_accum  = acc21;
                        st_work.digits_left = dl;
                        if (dl == 3'd0) begin
                            // Sequence complete: reject overlongs, surrogates
                            // and values beyond the Unicode range.
                            if ((st.seq_length == 2'd1 && acc21 < 21'h80) ||
                                (st.seq_length == 2'd2 && acc21 < 21'h800) ||
                                (st.seq_length == 2'd3 && acc21 < 21'h10000) ||
                                (acc21 >= 21'hD800 && acc21 <= 21'hDFFF) ||
                                (acc21 > 21'h10FFFF)) begin
                                act      = ACT_ERROR;
                                act_code = jsud_pkg::ERR_UTF8;
                            end
                            else begin
                                act    = ACT_EMIT;
                                act_cp = acc21;
                            end
                        end
                    end
                end
                jsud_pkg::PH_ESC:
                begin
                    case (in_byte)
                        8'h22, 8'h5C, 8'h2F:
                        begin
                            act    = ACT_EMIT;
                            act_cp = {13'd0, in_byte};
                        end
                        8'h62:
                        begin
                            act    = ACT_EMIT;
                            act_cp = 21'h08;
                        end
                        8'h66:
                        begin
                            act    = ACT_EMIT;
                            act_cp = 21'h0C;
                        end
                        8'h6E:
                        begin
                            act    = ACT_EMIT;
                            act_cp = 21'h0A;
                        end
                        8'h72:
                        begin
                            act    = ACT_EMIT;
                            act_cp = 21'h0D;
                        end
                        8'h74:
                        begin
                            act    = ACT_EMIT;
                            act_cp = 21'h09;
                        end
                        8'h75:
                        begin
                            st_work.code_accum  = 21'd0;
                            st_work.digits_left = 3'd4;
                            st_work.phase       = jsud_pkg::PH_HEXHI;
                        end
                        default:
                        begin
                            act      = ACT_ERROR;
                            act_code = jsud_pkg::ERR_SYNTAX;
                        end
                    endcase
                end
                jsud_pkg::PH_HEXHI, jsud_pkg::PH_HEXLO:
                begin
                    if (!hx[4]) begin
                        act      = ACT_ERROR;
                        act_code = jsud_pkg::ERR_SYNTAX;
                    end
                    else begin
                        st_work.code_accum  = {5'd0, acc16};
                        st_work.digits_left = dl;
                        if (dl == 3'd0) begin
                            if (ph == jsud_pkg::PH_HEXLO) begin
                                // Second half of a surrogate pair.
                                if (acc16 < 16'hDC00 || acc16 > 16'hDFFF) begin
                                    act      = ACT_ERROR;
                                    act_code = jsud_pkg::ERR_UTF8;
                                end
                                else begin
                                    act    = ACT_EMIT;
                                    act_cp = 21'h10000 + {1'b0, st.high_half, acc16[9:0]};
                                end
                            end
                            else if (acc16 >= 16'hD800 && acc16 <= 16'hDBFF) begin
                                st_work.high_half = acc16[9:0];
                                st_work.phase     = jsud_pkg::PH_WANTBS;
                            end
                            else if (acc16 >= 16'hDC00 && acc16 <= 16'hDFFF) begin
                                act      = ACT_ERROR;
                                act_code = jsud_pkg::ERR_UTF8;
                            end
                            else begin
                                act    = ACT_EMIT;
                                act_cp = {5'd0, acc16};
                            end
                        end
                    end
                end
                jsud_pkg::PH_WANTBS:
                begin
                    if (in_byte != 8'h5C) begin
                        act      = ACT_ERROR;
                        act_code = jsud_pkg::ERR_UTF8;
                    end
                    else begin
                        st_work.phase = jsud_pkg::PH_WANTU;
                    end
                end
                jsud_pkg::PH_WANTU:
                begin
                    if (in_byte != 8'h75) begin
                        act      = ACT_ERROR;
                        act_code = jsud_pkg::ERR_UTF8;
                    end
                    else begin
                        st_work.code_accum  = 21'd0;
                        st_work.digits_left = 3'd4;
                        st_work.phase       = jsud_pkg::PH_HEXLO;
                    end
                end
                default:
                begin
                    act      = ACT_ERROR;
                    act_code = jsud_pkg::ERR_SYNTAX;
                end
            endcase
        end
    end

    // UTF-8 encoding of the code point to be emitted.
    always_comb
    begin
        enc_bytes = '0;
        if (act_cp < 21'h80) begin
            enc_n        = 3'd1;
            enc_bytes[0] = act_cp[7:0];
        end
        else if (act_cp < 21'h800) begin
            enc_n        = 3'd2;
            enc_bytes[0] = {3'b110, act_cp[10:6]};
            enc_bytes[1] = {2'b10, act_cp[5:0]};
        end
        else if (act_cp < 21'h10000) begin
            enc_n        = 3'd3;
            enc_bytes[0] = {4'b1110, act_cp[15:12]};
            enc_bytes[1] = {2'b10, act_cp[11:6]};
            enc_bytes[2] = {2'b10, act_cp[5:0]};
        end
        else begin
            enc_n        = 3'd4;
            enc_bytes[0] = {5'b11110, act_cp[20:18]};
            enc_bytes[1] = {2'b10, act_cp[17:12]};
            enc_bytes[2] = {2'b10, act_cp[11:6]};
            enc_bytes[3] = {2'b10, act_cp[5:0]};
        end
    end

    // The whole chunk must fit in the pool, or nothing of it is written.
    assign fill_sum = {1'b0, st.pool_fill} + {14'd0, enc_n};
    assign pool_ok  = (fill_sum <= {1'b0, pool_capacity});

    // Next state.
    always_comb
    begin
        st_next = st_work;
        case (act)
            ACT_CLEAR:
            begin
                st_next = jsud_pkg::STATE_INIT;
            end
            ACT_EMIT:
            begin
                if (pool_ok) begin
                    st_next.pool_fill = fill_sum[15:0];
                    st_next.phase     = jsud_pkg::PH_PLAIN;
                end
                else begin
                    st_next.phase = jsud_pkg::PH_ERR_POOL;
                end
            end
            ACT_ERROR:
            begin
                st_next.phase = phase_of_err(act_code);
            end
            ACT_DONE:
            begin
                st_next.string_start = st.pool_fill;
                st_next.phase        = jsud_pkg::PH_IDLE;
            end
            default:
            begin
                st_next = st_work;
            end
        endcase
    end

    // Results of this request.
    always_comb
    begin
        res = '0;
        case (act)
            ACT_EMIT:
            begin
                if (pool_ok) begin
                    res.count   = enc_n;
                    res.is_byte = 1'b1;
                    res.bytes   = enc_bytes;
                end
                else begin
                    res.count = 3'd1;
                    res.err   = jsud_pkg::ERR_POOL;
                end
            end
            ACT_ERROR:
            begin
                res.count = 3'd1;
                res.err   = act_code;
            end
            ACT_DONE:
            begin
                res.count  = 3'd1;
                res.done   = 1'b1;
                res.length = st.pool_fill - st.string_start;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/jsud_decode_checker.sv]
// Watches the configuration, request and result channels of the string decoder.
// Each accepted request is decoded here into the bytes, done marks and errors
// that the block should return, and each accepted result is compared against them.
module jsud_decode_checker
    import jsud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [0] out_valid, [8:1] decoded_byte, [9] string_done,
                                   // [25:10] decoded_length, [27:26] error_code, [31:28] zero
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  data_byte;
        logic        done;
        logic [15:0] length;
        logic [1:0]  err;
        logic        last;
    } decoded_result_t;

    decoded_result_t decoded_q[$];
    int              mismatch_total;

    // Our own copy of the decoder state and the capacity register.
    phase_t      ph;
    logic [20:0] acc;
    logic [9:0]  hi_half;
    logic [2:0]  left;
    logic [1:0]  seq_len;
    logic [15:0] fill;
    logic [15:0] str_start;
    logic [15:0] cap;
    logic        latched;
    logic [1:0]  latched_err;

    function automatic void clear_decoder();
        ph          = PH_PLAIN;
        acc         = '0;
        hi_half     = '0;
        left        = '0;
        seq_len     = '0;
        fill        = '0;
        str_start   = '0;
        latched     = 1'b0;
        latched_err = ERR_NONE;
    endfunction

    function automatic void queue_result(logic ov, logic [7:0] b, logic done,
                                         logic [15:0] len, logic [1:0] err, logic last);
        decoded_result_t r;
        r.out_valid = ov;
        r.data_byte = b;
        r.done      = done;
        r.length    = len;
        r.err       = err;
        r.last      = last;
        decoded_q.push_back(r);
    endfunction

    // An error gives a single status result and holds until the next document.
    function automatic void flag_error(logic [1:0] code);
        latched     = 1'b1;
        latched_err = code;
        queue_result(1'b0, 8'd0, 1'b0, 16'd0, code, 1'b1);
    endfunction

    // Encode a code point as UTF-8 and emit it only if the whole chunk fits the pool.
    function automatic void emit_codepoint(logic [20:0] cp);
        logic [7:0] seq [4];
        int         n;
        if (cp < 21'h80) begin
            seq[0] = cp[7:0];
            n = 1;
        end
        else if (cp < 21'h800) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            n = 2;
        end
        else if (cp < 21'h10000) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            n = 3;
        end
        else begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        if (int'(fill) + n > int'(cap)) begin
            flag_error(ERR_POOL);
        end
        else begin
            fill = fill + 16'(n);
            for (int k = 0; k < n; k++)
                queue_result(1'b1, seq[k], 1'b0, 16'd0, ERR_NONE, k == n - 1);
            ph = PH_PLAIN;
        end
    endfunction

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    // Works out the results that one request should cause.
    function automatic void decode_request(logic [1:0] mode, logic [7:0] b);
        int h;
        if (mode == MODE_NEWDOC) begin
            clear_decoder();
            return;
        end
        if (mode == MODE_UNUSED)
            return;
        if (latched) begin
            queue_result(1'b0, 8'd0, 1'b0, 16'd0, latched_err, 1'b1);
            return;
        end
        if (mode == MODE_BUFEND) begin
            if (ph == PH_IDLE)
                return;
            if (ph == PH_CONT || ph == PH_WANTBS || ph == PH_WANTU)
                flag_error(ERR_UTF8);
            else
                flag_error(ERR_SYNTAX);
            return;
        end

        // A data byte after a closed string opens the next one.
        if (ph == PH_IDLE)
            ph = PH_PLAIN;
        case (ph)
            PH_PLAIN: begin
                if (b == "\"") begin
                    queue_result(1'b0, 8'd0, 1'b1, fill - str_start, ERR_NONE, 1'b1);
                    str_start = fill;
                    ph = PH_IDLE;
                end
                else if (b < 8'h20)
                    flag_error(ERR_SYNTAX);
                else if (b == "\\")
                    ph = PH_ESC;
                else if (b < 8'h80)
                    emit_codepoint({13'd0, b});
                else if (b[7:5] == 3'b110) begin
                    if (b[4:0] < 5'd2)
                        flag_error(ERR_UTF8);
                    else begin
                        seq_len = 2'd1;
                        acc = {16'd0, b[4:0]};
                        left = 3'd1;
                        ph = PH_CONT;
                    end
                end
                else if (b[7:4] == 4'b1110) begin
                    seq_len = 2'd2;
                    acc = {17'd0, b[3:0]};
                    left = 3'd2;
                    ph = PH_CONT;
                end
                else if (b[7:3] == 5'b11110) begin
                    if (b[2:0] > 3'd4)
                        flag_error(ERR_UTF8);
                    else begin
                        seq_len = 2'd3;
                        acc = {18'd0, b[2:0]};
                        left = 3'd3;
                        ph = PH_CONT;
                    end
                end
                else
                    flag_error(ERR_UTF8);
            end
            PH_CONT: begin
                if (b[7:6] != 2'b10)
                    flag_error(ERR_UTF8);
                else begin
                    acc = {acc[14:0], b[5:0]};
                    left = left - 3'd1;
                    if (left == 3'd0) begin
                        // Overlong forms, surrogates and values past the top plane.
                        if ((seq_len == 2'd1 && acc < 21'h80) ||
                            (seq_len == 2'd2 && acc < 21'h800) ||
                            (seq_len == 2'd3 && acc < 21'h10000) ||
                            (acc >= 21'hD800 && acc <= 21'hDFFF) ||
                            acc > 21'h10FFFF)
                            flag_error(ERR_UTF8);
                        else
                            emit_codepoint(acc);
                    end
                end
            end
            PH_ESC: begin
                case (b)
                    "\"", "\\", "/": emit_codepoint({13'd0, b});
                    "b": emit_codepoint(21'h08);
                    "f": emit_codepoint(21'h0C);
                    "n": emit_codepoint(21'h0A);
                    "r": emit_codepoint(21'h0D);
                    "t": emit_codepoint(21'h09);
                    "u": begin
                        acc = '0;
                        left = 3'd4;
                        ph = PH_HEXHI;
                    end
                    default: flag_error(ERR_SYNTAX);
                endcase
            end
            PH_HEXHI, PH_HEXLO: begin
                h = hex_value(b);
                if (h < 0)
                    flag_error(ERR_SYNTAX);
                else begin
                    acc = {5'd0, acc[11:0], h[3:0]};
                    left = left - 3'd1;
                    if (left == 3'd0) begin
                        if (ph == PH_HEXLO) begin
                            if (acc < 21'hDC00 || acc > 21'hDFFF)
                                flag_error(ERR_UTF8);
                            else
                                emit_codepoint(21'h10000 + {hi_half, 10'd0} + (acc - 21'hDC00));
                        end
                        else if (acc >= 21'hD800 && acc <= 21'hDBFF) begin
                            // High half of a pair: the low half must follow as \u.
                            hi_half = acc[9:0];
                            ph = PH_WANTBS;
                        end
                        else if (acc >= 21'hDC00 && acc <= 21'hDFFF)
                            flag_error(ERR_UTF8);
                        else
                            emit_codepoint(acc);
                    end
                end
            end
            PH_WANTBS: begin
                if (b != "\\")
                    flag_error(ERR_UTF8);
                else
                    ph = PH_WANTU;
            end
            PH_WANTU: begin
                if (b != "u")
                    flag_error(ERR_UTF8);
                else begin
                    acc = '0;
                    left = 3'd4;
                    ph = PH_HEXLO;
                end
            end
            default: flag_error(ERR_SYNTAX);
        endcase
    endfunction

    // Compares one accepted result with the oldest outstanding expectation.
    function automatic void check_result();
        decoded_result_t want;
        if (decoded_q.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("%0t: result with nothing outstanding: tdata %h tlast %0b",
                         $time, m_tdata, m_tlast);
            return;
        end
        want = decoded_q.pop_front();
        if (m_tdata[0] !== want.out_valid || m_tdata[8:1] !== want.data_byte ||
            m_tdata[9] !== want.done || m_tdata[25:10] !== want.length ||
            m_tdata[27:26] !== want.err || m_tdata[31:28] !== 4'd0 ||
            m_tlast !== want.last) begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display({"%0t: result mismatch: expected valid %0b byte %h done %0b len %0d ",
                          "err %0d last %0b, got valid %0b byte %h done %0b len %0d err %0d ",
                          "last %0b pad %h"},
                         $time, want.out_valid, want.data_byte, want.done, want.length,
                         want.err, want.last, m_tdata[0], m_tdata[8:1], m_tdata[9],
                         m_tdata[25:10], m_tdata[27:26], m_tlast, m_tdata[31:28]);
        end
    endfunction

    // Requests are decoded before results are checked; a result never belongs
    // to a request taken at the same edge. A capacity written at an edge only
    // applies to requests taken after it.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_decoder();
            cap = POOL_CAP_RESET;
            decoded_q.delete();
            mismatch_total = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else begin
            if (s_tvalid && s_tready)
                decode_request(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready)
                cap = cfg_data;
            if (m_tvalid && m_tready)
                check_result();
            fail_count <= mismatch_total;
            pending <= decoded_q.size();
        end
    end

endmodule

[tb/json_string_unescape_decoder_tb.sv]
// Drives JSON string bytes into the decoder, with random gaps on both channels,
// and gives the verdict from the checker's counts.
module json_string_unescape_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsud_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_REQUESTS = 450;
    localparam int PHASES          = 6;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic [1:0]  s_tuser;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [0] out_valid, [8:1] decoded_byte, [9] string_done,
                            // [25:10] decoded_length, [27:26] error_code, [31:28] zero
    logic        m_tlast;

    int   mismatches;
    int   outstanding;
    int   cycles = 0;
    int   requests_sent = 0;
    int   send_calm = 0;
    int   take_calm = 0;
    logic tainted = 1'b0;

    json_string_unescape_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    jsud_decode_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (mismatches),
        .pending    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(15, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // The result side stalls at random.
    initial
    begin
        int gap;
        forever
        begin
            gap = pick_gap(take_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_req(input logic [1:0] mode, input logic [7:0] b);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        if (mode != MODE_UNUSED)
            requests_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(MODE_DATA, b);
    endtask

    // Holds the request side until every outstanding result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + nib;
        return ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_escape_char(logic [7:0] c);
        case (c)
            "\"", "\\", "/", "b", "f", "n", "r", "t", "u": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] any_cont();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_u_escape(input logic [15:0] v);
        send_byte("\\");
        send_byte("u");
        for (int i = 3; i >= 0; i--)
            send_byte(hex_char(v[i*4 +: 4]));
    endtask

    task automatic send_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
            send_byte(cp[7:0]);
        else if (cp < 21'h800)
        begin
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end
        else
        begin
            send_byte({5'b11110, cp[20:18]});
            send_byte({2'b10, cp[17:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [15:0] pick_bmp();
        logic [15:0] v;
        case ($urandom_range(0, 2))
            0: v = 16'($urandom_range(0, 16'h7F));
            1: v = 16'($urandom_range(16'h80, 16'h7FF));
            default:
            begin
                do
                    v = 16'($urandom_range(16'h800, 16'hFFFF));
                while (v >= 16'hD800 && v <= 16'hDFFF);
            end
        endcase
        return v;
    endfunction

    // One well-formed piece of string content.
    task automatic send_good_piece();
        logic [7:0]  b;
        logic [20:0] cp;
        case ($urandom_range(0, 9))
            0, 1, 2, 9:
            begin
                b = 8'($urandom_range(8'h20, 8'h7F));
                if (b == "\"" || b == "\\")
                    b = "q";
                send_byte(b);
            end
            3:
            begin
                send_byte("\\");
                case ($urandom_range(0, 7))
                    0: send_byte("\"");
                    1: send_byte("\\");
                    2: send_byte("/");
                    3: send_byte("b");
                    4: send_byte("f");
                    5: send_byte("n");
                    6: send_byte("r");
                    default: send_byte("t");
                endcase
            end
            4: send_u_escape(pick_bmp());
            5:
            begin
                send_u_escape(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
                send_u_escape(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
            end
            6: send_utf8(21'($urandom_range(21'h80, 21'h7FF)));
            7:
            begin
                do
                    cp = 21'($urandom_range(21'h800, 21'hFFFF));
                while (cp >= 21'hD800 && cp <= 21'hDFFF);
                send_utf8(cp);
            end
            default: send_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)));
        endcase
    endtask

    // One piece that is most likely malformed, drawn from kinds of bad input the decoder must reject.
    task automatic send_bad_piece();
        logic [7:0]  b;
        logic [15:0] v;
        tainted = 1'b1;
        case ($urandom_range(0, 10))
            0: send_byte(any_byte());
            1: send_byte(8'($urandom_range(0, 8'h1F)));
            2:
            begin
                send_byte("\\");
                do
                    b = any_byte();
                while (is_escape_char(b));
                send_byte(b);
            end
            3:
            begin
                send_byte("\\");
                send_byte("u");
                repeat ($urandom_range(0, 3))
                    send_byte(hex_char(4'($urandom_range(0, 15))));
                do
                    b = any_byte();
                while (is_hex(b));
                send_byte(b);
            end
            4:
            begin
                // Overlong two-byte lead.
                send_byte(8'hC0 + 8'($urandom_range(0, 1)));
                send_byte(any_cont());
            end
            5:
            begin
                // Overlong three-byte form or a raw surrogate.
                if ($urandom_range(0, 1))
                begin
                    send_byte(8'hE0);
                    send_byte(8'($urandom_range(8'h80, 8'h9F)));
                end
                else
                begin
                    send_byte(8'hED);
                    send_byte(8'($urandom_range(8'hA0, 8'hBF)));
                end
                send_byte(any_cont());
            end
            6:
            begin
                // Four-byte forms out of range, overlong, or with an invalid lead.
                case ($urandom_range(0, 2))
                    0:
                    begin
                        send_byte(8'hF4);
                        send_byte(8'($urandom_range(8'h90, 8'hBF)));
                    end
                    1:
                    begin
                        send_byte(8'hF0);
                        send_byte(8'($urandom_range(8'h80, 8'h8F)));
                    end
                    default: send_byte(8'($urandom_range(8'hF5, 8'hFF)));
                endcase
                send_byte(any_cont());
                send_byte(any_cont());
            end
            7:
            begin
                // A lead byte followed by something that is not a continuation.
                case ($urandom_range(0, 2))
                    0: send_byte(8'($urandom_range(8'hC2, 8'hDF)));
                    1: send_byte(8'hE1);
                    default: send_byte(8'hF1);
                endcase
                b = 8'($urandom_range(0, 191));
                if (b >= 8'h80)
                    b = b + 8'h40;
                send_byte(b);
            end
            8: send_u_escape(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
            9:
            begin
                // High surrogate escape without a proper low half.
                send_u_escape(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
                case ($urandom_range(0, 2))
                    0:
                    begin
                        do
                            b = any_byte();
                        while (b == "\\");
                        send_byte(b);
                    end
                    1:
                    begin
                        send_byte("\\");
                        do
                            b = any_byte();
                        while (b == "u");
                        send_byte(b);
                    end
                    default:
                    begin
                        do
                            v = 16'($urandom_range(0, 16'hFFFF));
                        while (v >= 16'hDC00 && v <= 16'hDFFF);
                        send_u_escape(v);
                    end
                endcase
            end
            default:
            begin
                // Buffer ends part way through an escape or a multibyte sequence.
                case ($urandom_range(0, 2))
                    0: send_byte("\\");
                    1: send_byte(8'hE2);
                    default:
                    begin
                        send_byte("\\");
                        send_byte("u");
                        send_byte("1");
                    end
                endcase
                send_req(MODE_BUFEND, any_byte());
            end
        endcase
    endtask

    task automatic send_string();
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 99) < 8)
                send_bad_piece();
            else
                send_good_piece();
        end
        if ($urandom_range(0, 99) < 4)
        begin
            tainted = 1'b1;
            send_req(MODE_BUFEND, any_byte());
        end
        else
            send_byte("\"");
        if ($urandom_range(0, 99) < 20)
            send_req(MODE_BUFEND, any_byte());
        if ($urandom_range(0, 99) < 3)
            send_req(MODE_UNUSED, any_byte());
    endtask

    task automatic send_document();
        repeat ($urandom_range(1, 3))
            send_string();
        if (tainted || $urandom_range(0, 1))
        begin
            send_req(MODE_NEWDOC, any_byte());
            tainted = 1'b0;
        end
    endtask

    initial
    begin
        logic [15:0] caps [PHASES];
        int          base;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tuser   <= MODE_DATA;
        cfg_valid <= 1'b0;
        cfg_data  <= 16'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset capacity.
        send_byte("a");
        send_byte(8'h7F);
        send_byte("\\");
        send_byte("n");
        send_byte(8'hC3);
        send_byte(8'hA9);
        // Highest code point: four bytes out from one request.
        send_byte(8'hF4);
        send_byte(8'h8F);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_byte("\"");
        send_req(MODE_BUFEND, 8'h00);
        send_req(MODE_UNUSED, 8'hFF);
        // A raw control byte, then the latched error repeats.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_req(MODE_BUFEND, 8'hFF);
        send_req(MODE_NEWDOC, 8'h5A);
        send_byte(8'hFF);
        send_req(MODE_NEWDOC, 8'h00);
        // Buffer ends while the low half of a surrogate pair is still owed.
        send_u_escape(16'hD83D);
        send_byte("\\");
        send_req(MODE_BUFEND, 8'h00);
        send_req(MODE_NEWDOC, 8'h00);

        // A chunk that does not fit the pool is dropped whole.
        wait_idle();
        write_capacity(16'd3);
        send_byte("a");
        send_byte("b");
        send_byte(8'hC3);
        send_byte(8'hA9);
        send_req(MODE_NEWDOC, 8'h00);

        // Random documents over a range of capacities. The pool is not cleared
        // between phases, so a capacity below the current fill is also reached.
        caps[0] = 16'hFFFF;
        caps[1] = 16'd0;
        caps[2] = 16'd9;
        caps[3] = 16'd40;
        caps[4] = 16'($urandom_range(0, 16'hFFFF));
        caps[5] = POOL_CAP_RESET;
        base = requests_sent;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_capacity(caps[p]);
            while (requests_sent < base + (p + 1) * RANDOM_REQUESTS / PHASES)
                send_document();
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
